[rtl/oapf_pkg.sv]
// ============================================================================
// oapf_pkg: shared constants for the obstacle-avoid / wall-follow controller
// Register indexes, command codes, follow-side codes and fixed field widths.
// ============================================================================
package oapf_pkg;

    // Default sensor reading width
    localparam int SENSOR_BITS_DEF = 12;

    // Fixed field widths
    localparam int TH_W    = 12;   // thresholds, target, deadband
    localparam int LIMIT_W = 20;   // integral clamp bound
    localparam int GAIN_W  = 16;   // signed Q8.8 gains
    localparam int MATCH_W = 16;   // wheel match limit
    localparam int POS_W   = 32;   // wheel positions
    localparam int SPEED_W = 16;   // speed correction
    localparam int TURN_W  = 2;
    localparam int SIDE_W  = 2;
    localparam int Q_FRAC  = 8;    // fraction bits of the gains

    // Integral register holds +-(2^LIMIT_W - 1)
    localparam int INTEG_W = LIMIT_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRONT_THRESHOLD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_TARGET          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_DEADBAND       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P               = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I               = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D               = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MATCH_LIMIT = 3'd7;

    // Turn commands
    localparam logic [TURN_W-1:0] NO_OBST    = 2'd0;
    localparam logic [TURN_W-1:0] TURN_LEFT  = 2'd1;
    localparam logic [TURN_W-1:0] TURN_RIGHT = 2'd2;

    // Follow side: which side sensor feeds the PID
    localparam logic [SIDE_W-1:0] SIDE_NONE  = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd2;

    // Zero value for a wheel position
    localparam logic signed [POS_W-1:0] WHEEL_POS_ZERO = '0;

    // Register reset values
    localparam logic [TH_W-1:0]             FRONT_THRESHOLD_RST = 12'd100;
    localparam logic [TH_W-1:0]             SIDE_TARGET_RST     = 12'd100;
    localparam logic [TH_W-1:0]             DEADBAND_RST        = 12'd10;
    localparam logic [LIMIT_W-1:0]          INTEGRAL_LIMIT_RST  = 20'd1000;
    localparam logic signed [GAIN_W-1:0]    GAIN_P_RST          = 16'sd256;
    localparam logic signed [GAIN_W-1:0]    GAIN_I_RST          = 16'sd0;
    localparam logic signed [GAIN_W-1:0]    GAIN_D_RST          = 16'sd0;
    localparam logic [MATCH_W-1:0]          MATCH_LIMIT_RST     = 16'd10;

    // Per-item flags carried down the pipeline
    typedef struct packed {
        logic [TURN_W-1:0] turn;
        logic              run;
        logic              neg;
        logic              resume;
        logic              fwd;
    } ctl_t;

endpackage

[rtl/oapf_in_if.sv]
// ============================================================================
// oapf_in_if: sensor tick channel
// Valid/ready channel carrying one control tick of sensor and wheel data.
// ============================================================================
interface oapf_in_if #(
    parameter int SENSOR_BITS = oapf_pkg::SENSOR_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [SENSOR_BITS-1:0]            front_right_near;
    logic [SENSOR_BITS-1:0]            front_right_far;
    logic [SENSOR_BITS-1:0]            front_left_far;
    logic [SENSOR_BITS-1:0]            front_left_near;
    logic [SENSOR_BITS-1:0]            side_right;
    logic [SENSOR_BITS-1:0]            side_left;
    logic                              rotation_finished;
    logic signed [oapf_pkg::POS_W-1:0] left_wheel_pos;
    logic signed [oapf_pkg::POS_W-1:0] right_wheel_pos;

    modport source (
        output valid, front_right_near, front_right_far, front_left_far,
               front_left_near, side_right, side_left, rotation_finished,
               left_wheel_pos, right_wheel_pos,
        input  ready
    );

    modport sink (
        input  valid, front_right_near, front_right_far, front_left_far,
               front_left_near, side_right, side_left, rotation_finished,
               left_wheel_pos, right_wheel_pos,
        output ready
    );
endinterface

[rtl/oapf_out_if.sv]
// ============================================================================
// oapf_out_if: control result channel
// Valid/ready channel carrying turn command, PID speed and mode flags.
// ============================================================================
interface oapf_out_if;
    logic                                valid;
    logic                                ready;
    logic [oapf_pkg::TURN_W-1:0]         turn_command;
    logic                                speed_valid;
    logic signed [oapf_pkg::SPEED_W-1:0] wheel_speed_adjust;
    logic                                resume_forward;
    logic                                forward_mode;

    modport source (
        output valid, turn_command, speed_valid, wheel_speed_adjust,
               resume_forward, forward_mode,
        input  ready
    );

    modport sink (
        input  valid, turn_command, speed_valid, wheel_speed_adjust,
               resume_forward, forward_mode,
        output ready
    );
endinterface

[rtl/obstacle_avoid_pid_follow.sv]
// ============================================================================
// obstacle_avoid_pid_follow: obstacle avoidance with side-wall PID following
// Four-stage pipeline: input register, decision/state, products, result.
// ============================================================================
// Usage:
//   in_ch  : one beat per control tick (front/side readings, rotation done,
//            wheel positions). A beat is taken when valid and ready are high.
//   out_ch : one result beat per input beat, in order: turn command, PID
//            speed correction with its valid flag, resume flag, forward mode.
//   cfg_*  : write-only register port; write only while the block is idle.
// Path: an accepted beat passes the input, decision, product and result
//   registers. Throughput: one beat per cycle while out_ch does not stall. The
//   controller state (mode, follow side, integral, last error) is updated in
//   the single decision stage, so the next beat sees it; the three gain
//   multiplies have their own stage, the sum, scaling and saturation the last.
// Each stage has its own valid bit and takes a new beat whenever it is empty
//   or its content moves on, so bubbles close up under a stall. When out_ch
//   stalls, up to four beats are held before in_ch.ready drops.
// Reset: all stage valid bits clear, forward mode on, no follow side,
//   integral and last error zero, registers at their default values.
// ============================================================================
module obstacle_avoid_pid_follow #(
    parameter int SENSOR_BITS = oapf_pkg::SENSOR_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    oapf_in_if.sink                               in_ch,
    oapf_out_if.source                            out_ch,
    input  logic                                  cfg_we,
    input  logic [oapf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [oapf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int TH_W    = oapf_pkg::TH_W;
    localparam int CMP_W   = (SENSOR_BITS > TH_W) ? SENSOR_BITS : TH_W;
    localparam int E_W     = CMP_W + 1;
    localparam int D_W     = E_W + 1;
    localparam int INTEG_W = oapf_pkg::INTEG_W;
    localparam int SUM_W   = INTEG_W + 1;
    localparam int GAIN_W  = oapf_pkg::GAIN_W;
    localparam int PP_W    = GAIN_W + E_W;
    localparam int PI_W    = GAIN_W + INTEG_W;
    localparam int PD_W    = GAIN_W + D_W;
    localparam int ACC_W   = GAIN_W + INTEG_W + 2;
    localparam int SPEED_W = oapf_pkg::SPEED_W;
    localparam int POS_W   = oapf_pkg::POS_W;
    localparam int DIFF_W  = POS_W + 1;
    localparam int Q_FRAC  = oapf_pkg::Q_FRAC;

    localparam logic signed [SPEED_W-1:0] SPD_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] SPD_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TH_W-1:0]                     front_threshold_reg;
    logic [TH_W-1:0]                     side_target_reg;
    logic [TH_W-1:0]                     error_deadband_reg;
    logic [oapf_pkg::LIMIT_W-1:0]        integral_limit_reg;
    logic signed [GAIN_W-1:0]            gain_p_reg;
    logic signed [GAIN_W-1:0]            gain_i_reg;
    logic signed [GAIN_W-1:0]            gain_d_reg;
    logic [oapf_pkg::MATCH_W-1:0]        match_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_threshold_reg <= oapf_pkg::FRONT_THRESHOLD_RST;
            side_target_reg     <= oapf_pkg::SIDE_TARGET_RST;
            error_deadband_reg  <= oapf_pkg::DEADBAND_RST;
            integral_limit_reg  <= oapf_pkg::INTEGRAL_LIMIT_RST;
            gain_p_reg          <= oapf_pkg::GAIN_P_RST;
            gain_i_reg          <= oapf_pkg::GAIN_I_RST;
            gain_d_reg          <= oapf_pkg::GAIN_D_RST;
            match_limit_reg     <= oapf_pkg::MATCH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                oapf_pkg::REG_FRONT_THRESHOLD:
                    front_threshold_reg <= cfg_data[TH_W-1:0];
                oapf_pkg::REG_SIDE_TARGET:
                    side_target_reg <= cfg_data[TH_W-1:0];
                oapf_pkg::REG_ERROR_DEADBAND:
                    error_deadband_reg <= cfg_data[TH_W-1:0];
                oapf_pkg::REG_INTEGRAL_LIMIT:
                    integral_limit_reg <= cfg_data[oapf_pkg::LIMIT_W-1:0];
                oapf_pkg::REG_GAIN_P:
                    gain_p_reg <= $signed(cfg_data[GAIN_W-1:0]);
                oapf_pkg::REG_GAIN_I:
                    gain_i_reg <= $signed(cfg_data[GAIN_W-1:0]);
                oapf_pkg::REG_GAIN_D:
                    gain_d_reg <= $signed(cfg_data[GAIN_W-1:0]);
                oapf_pkg::REG_POSITION_MATCH_LIMIT:
                    match_limit_reg <= cfg_data[oapf_pkg::MATCH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when empty or draining
    // ------------------------------------------------------------------
    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    assign rdy_d = !vld_d_reg || out_ch.ready;
    assign rdy_c = !vld_c_reg || rdy_d;
    assign rdy_b = !vld_b_reg || rdy_c;
    assign rdy_a = !vld_a_reg || rdy_b;

    assign in_ch.ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) vld_a_reg <= in_ch.valid;
            if (rdy_b) vld_b_reg <= vld_a_reg;
            if (rdy_c) vld_c_reg <= vld_b_reg;
            if (rdy_d) vld_d_reg <= vld_c_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic [SENSOR_BITS-1:0]   frn_reg, frf_reg, flf_reg, fln_reg, sr_reg, sl_reg;
    logic                     rot_reg;
    logic signed [POS_W-1:0]  lpos_reg, rpos_reg;

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_ch.valid)
        begin
            frn_reg  <= in_ch.front_right_near;
            frf_reg  <= in_ch.front_right_far;
            flf_reg  <= in_ch.front_left_far;
            fln_reg  <= in_ch.front_left_near;
            sr_reg   <= in_ch.side_right;
            sl_reg   <= in_ch.side_left;
            rot_reg  <= in_ch.rotation_finished;
            lpos_reg <= in_ch.left_wheel_pos;
            rpos_reg <= in_ch.right_wheel_pos;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic                          fwd_reg;
    logic [oapf_pkg::SIDE_W-1:0]   side_reg;
    logic signed [INTEG_W-1:0]     integ_reg;
    logic signed [E_W-1:0]         last_reg;

    // ------------------------------------------------------------------
    // Stage B logic: obstacle decision, error, integral, wheel match
    // ------------------------------------------------------------------
    logic                          near_hit, far_hit, on_right, found;
    logic [CMP_W-1:0]              thr_x;
    logic                          fwd_mid;
    logic [oapf_pkg::SIDE_W-1:0]   side_mid;
    logic [oapf_pkg::TURN_W-1:0]   turn_b;
    logic                          run_b, end_b, close_b;
    logic [SENSOR_BITS-1:0]        side_val;
    logic signed [E_W-1:0]         e_raw, e_b;
    logic [E_W-1:0]                e_mag;
    logic signed [SUM_W-1:0]       sum_raw, lim_s;
    logic signed [INTEG_W-1:0]     sum_b;
    logic signed [D_W-1:0]         delta_b;
    logic signed [DIFF_W-1:0]      pos_diff;
    logic [DIFF_W-1:0]             pos_mag;
    logic                          fwd_next;
    logic [oapf_pkg::SIDE_W-1:0]   side_next;
    logic signed [INTEG_W-1:0]     integ_next;
    logic signed [E_W-1:0]         last_next;

    always_comb
    begin
        // front obstacle: near pair first, then far pair; a tie turns right
        thr_x    = CMP_W'(front_threshold_reg);
        near_hit = (CMP_W'(frn_reg) > thr_x) || (CMP_W'(fln_reg) > thr_x);
        far_hit  = (CMP_W'(frf_reg) > thr_x) || (CMP_W'(flf_reg) > thr_x);
        on_right = near_hit ? (frn_reg > fln_reg) : (frf_reg > flf_reg);
        found    = fwd_reg && (near_hit || far_hit);

        turn_b   = oapf_pkg::NO_OBST;
        fwd_mid  = fwd_reg;
        side_mid = side_reg;
        if (found)
        begin
            fwd_mid  = 1'b0;
            turn_b   = on_right ? oapf_pkg::TURN_LEFT : oapf_pkg::TURN_RIGHT;
            side_mid = on_right ? oapf_pkg::SIDE_RIGHT : oapf_pkg::SIDE_LEFT;
        end

        run_b = (side_mid != oapf_pkg::SIDE_NONE) && rot_reg;

        // error with deadband
        side_val = (side_mid == oapf_pkg::SIDE_LEFT) ? sl_reg : sr_reg;
        e_raw    = $signed({1'b0, CMP_W'(side_target_reg)})
                 - $signed({1'b0, CMP_W'(side_val)});
        e_mag    = e_raw[E_W-1] ? E_W'(-e_raw) : E_W'(e_raw);
        e_b      = (e_mag < E_W'(error_deadband_reg)) ? '0 : e_raw;

        // integral with symmetric clamp
        lim_s   = $signed({2'b00, integral_limit_reg});
        sum_raw = SUM_W'(integ_reg) + SUM_W'(e_b);
        if (sum_raw > lim_s)
            sum_b = INTEG_W'(lim_s);
        else if (sum_raw < -lim_s)
            sum_b = INTEG_W'(-lim_s);
        else
            sum_b = INTEG_W'(sum_raw);

        delta_b = D_W'(e_b) - D_W'(last_reg);

        // wheel positions agree
        pos_diff = DIFF_W'(lpos_reg) - DIFF_W'(rpos_reg);
        pos_mag  = pos_diff[DIFF_W-1] ? DIFF_W'(-pos_diff) : DIFF_W'(pos_diff);
        close_b  = pos_mag < DIFF_W'(match_limit_reg);
        end_b    = run_b && close_b;

        // next state
        fwd_next   = end_b ? 1'b1 : fwd_mid;
        side_next  = end_b ? oapf_pkg::SIDE_NONE : side_mid;
        integ_next = integ_reg;
        last_next  = last_reg;
        if (run_b)
        begin
            integ_next = end_b ? '0 : sum_b;
            last_next  = e_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= 1'b1;
            side_reg  <= oapf_pkg::SIDE_NONE;
            integ_reg <= '0;
            last_reg  <= '0;
        end
        else if (rdy_b && vld_a_reg)
        begin
            fwd_reg   <= fwd_next;
            side_reg  <= side_next;
            integ_reg <= integ_next;
            last_reg  <= last_next;
        end
    end

    // Stage B register
    oapf_pkg::ctl_t            ctl_b_reg;
    logic signed [E_W-1:0]     e_b_reg;
    logic signed [INTEG_W-1:0] sum_b_reg;
    logic signed [D_W-1:0]     delta_b_reg;

    always_ff @(posedge clk)
    begin
        if (rdy_b && vld_a_reg)
        begin
            ctl_b_reg.turn   <= turn_b;
            ctl_b_reg.run    <= run_b;
            ctl_b_reg.neg    <= (side_mid == oapf_pkg::SIDE_LEFT);
            ctl_b_reg.resume <= end_b;
            ctl_b_reg.fwd    <= fwd_next;
            e_b_reg          <= e_b;
            sum_b_reg        <= sum_b;
            delta_b_reg      <= delta_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: gain products
    // ------------------------------------------------------------------
    oapf_pkg::ctl_t          ctl_c_reg;
    logic signed [PP_W-1:0]  pp_reg;
    logic signed [PI_W-1:0]  pi_reg;
    logic signed [PD_W-1:0]  pd_reg;

    always_ff @(posedge clk)
    begin
        if (rdy_c && vld_b_reg)
        begin
            ctl_c_reg <= ctl_b_reg;
            pp_reg    <= PP_W'(gain_p_reg) * PP_W'(e_b_reg);
            pi_reg    <= PI_W'(gain_i_reg) * PI_W'(sum_b_reg);
            pd_reg    <= PD_W'(gain_d_reg) * PD_W'(delta_b_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage D logic: sum, scale toward zero, saturate, side sign
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]   acc, acc_bias, acc_q;
    logic                      fits;
    logic signed [SPEED_W-1:0] spd_sat, spd_d;

    always_comb
    begin
        acc      = ACC_W'(pp_reg) + ACC_W'(pi_reg) + ACC_W'(pd_reg);
        acc_bias = acc + $signed({{(ACC_W-Q_FRAC){1'b0}}, {Q_FRAC{acc[ACC_W-1]}}});
        acc_q    = acc_bias >>> Q_FRAC;
        fits     = (acc_q[ACC_W-1:SPEED_W-1] == '0)
                || (acc_q[ACC_W-1:SPEED_W-1] == '1);
        if (fits)
            spd_sat = acc_q[SPEED_W-1:0];
        else
            spd_sat = acc_q[ACC_W-1] ? SPD_MIN : SPD_MAX;

        if (!ctl_c_reg.run)
            spd_d = '0;
        else if (ctl_c_reg.neg)
            spd_d = (spd_sat == SPD_MIN) ? SPD_MAX : -spd_sat;
        else
            spd_d = spd_sat;
    end

    // Output register
    oapf_pkg::ctl_t            ctl_d_reg;
    logic signed [SPEED_W-1:0] spd_d_reg;

    always_ff @(posedge clk)
    begin
        if (rdy_d && vld_c_reg)
        begin
            ctl_d_reg <= ctl_c_reg;
            spd_d_reg <= spd_d;
        end
    end

    assign out_ch.valid              = vld_d_reg;
    assign out_ch.turn_command       = ctl_d_reg.turn;
    assign out_ch.speed_valid        = ctl_d_reg.run;
    assign out_ch.wheel_speed_adjust = spd_d_reg;
    assign out_ch.resume_forward     = ctl_d_reg.resume;
    assign out_ch.forward_mode       = ctl_d_reg.fwd;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // forward mode and an active follow side never coexist
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg == (side_reg == oapf_pkg::SIDE_NONE))
    else $error("forward mode and follow side disagree");

    // no PID output means a zero correction
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.speed_valid) |-> (out_ch.wheel_speed_adjust == '0))
    else $error("speed correction without PID run");

    // resuming requires a PID run and returns to forward mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.resume_forward)
            |-> (out_ch.speed_valid && out_ch.forward_mode))
    else $error("resume without PID run or forward mode");

    // a turn leaves forward mode unless following ended in the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.turn_command != oapf_pkg::NO_OBST)
            && !out_ch.resume_forward) |-> !out_ch.forward_mode)
    else $error("turn issued while staying in forward mode");

    // a state update happens only when a beat moves into the decision stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rdy_b && vld_a_reg) |=> $stable(fwd_reg) && $stable(side_reg))
    else $error("controller state changed without a beat");

endmodule

[tb/obstacle_avoid_pid_follow_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// obstacle_avoid_pid_follow_tb: self-checking bench for the avoid/follow unit
// Sends sensor ticks through the input channel and scores every result beat
// against an in-bench model of the turn decision, the follow-side PID and the
// resume logic. It steps through several register settings, including the
// extremes, and applies random idle gaps and stalls on both channels.
// ============================================================================
module obstacle_avoid_pid_follow_tb;

    localparam int SB          = oapf_pkg::SENSOR_BITS_DEF;
    localparam int CYCLE_LIMIT = 500000;

    localparam int POS_W      = oapf_pkg::POS_W;
    localparam int TURN_W     = oapf_pkg::TURN_W;
    localparam int SPEED_W    = oapf_pkg::SPEED_W;
    localparam int CFG_IDX_W  = oapf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = oapf_pkg::CFG_DATA_W;
    localparam int TH_W       = oapf_pkg::TH_W;
    localparam int LIMIT_W    = oapf_pkg::LIMIT_W;
    localparam int GAIN_W     = oapf_pkg::GAIN_W;
    localparam int MATCH_W    = oapf_pkg::MATCH_W;
    localparam int SIDE_W     = oapf_pkg::SIDE_W;

    // Idle gap modes
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_LIGHT = 1;
    localparam int IDLE_HEAVY = 2;

    // One control tick as sent on the input channel
    typedef struct {
        logic [SB-1:0]           fr_near, fr_far, fl_far, fl_near, side_r, side_l;
        logic                    rot_done;
        logic signed [POS_W-1:0] lpos, rpos;
        bit                      drain_first;   // hold back until all results are in
    } tick_t;

    // One result beat
    typedef struct packed {
        logic [TURN_W-1:0]         turn;
        logic                      spd_valid;
        logic signed [SPEED_W-1:0] speed;
        logic                      resume;
        logic                      fwd;
    } ctl_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    oapf_in_if #(.SENSOR_BITS(SB)) in_ch ();
    oapf_out_if                    out_ch ();

    obstacle_avoid_pid_follow #(.SENSOR_BITS(SB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Register shadow
    logic [TH_W-1:0]           thr_r, tgt_r, dband_r;
    logic [LIMIT_W-1:0]        ilim_r;
    logic signed [GAIN_W-1:0]  gp_r, gi_r, gd_r;
    logic [MATCH_W-1:0]        match_r;

    // Controller state copy
    logic              fwd_flag;
    logic [SIDE_W-1:0] side_sel;
    longint            integ_acc;
    longint            prev_err;

    tick_t       sensor_ticks[$];
    ctl_result_t expected_ctl[$];

    int ticks_queued = 0;
    int ticks_sent   = 0;
    int ctl_checked  = 0;
    int mismatches   = 0;
    int settings_cnt = 1;
    int turns_seen   = 0;
    int pid_runs     = 0;
    int resumes_seen = 0;
    int idle_mode    = IDLE_NONE;
    int cycles       = 0;
    int hold_left    = 0;
    int beats_in     = 0;
    int tx_gap;
    int rx_wait;
    tick_t       tx_tick;
    ctl_result_t tx_want;
    ctl_result_t rx_got, rx_want;

    // ------------------------------------------------------------------------
    // Model of one control tick
    // ------------------------------------------------------------------------
    function automatic longint clip16(input longint x);
        if (x > 32767)
            return 32767;
        if (x < -32768)
            return -32768;
        return x;
    endfunction

    function automatic ctl_result_t control_step(input tick_t t);
        ctl_result_t   r;
        bit            found;
        bit            obst_right;
        logic [SB-1:0] side;
        longint        err, mag, sum, acc, spd, diff;
        r          = '0;
        r.turn     = oapf_pkg::NO_OBST;
        found      = 1'b0;
        obst_right = 1'b0;
        // Near pair first, far pair only if the near pair is clear
        if (fwd_flag)
        begin
            if (t.fr_near > thr_r || t.fl_near > thr_r)
            begin
                found      = 1'b1;
                obst_right = t.fr_near > t.fl_near;
            end
            else if (t.fr_far > thr_r || t.fl_far > thr_r)
            begin
                found      = 1'b1;
                obst_right = t.fr_far > t.fl_far;
            end
            if (found)
            begin
                fwd_flag = 1'b0;
                r.turn   = obst_right ? oapf_pkg::TURN_LEFT : oapf_pkg::TURN_RIGHT;
                side_sel = obst_right ? oapf_pkg::SIDE_RIGHT : oapf_pkg::SIDE_LEFT;
            end
        end
        // PID on the follow-side sensor once the turn is done
        if (side_sel != oapf_pkg::SIDE_NONE && t.rot_done)
        begin
            side = (side_sel == oapf_pkg::SIDE_LEFT) ? t.side_l : t.side_r;
            err  = longint'(tgt_r) - longint'(side);
            mag  = (err < 0) ? -err : err;
            if (mag < longint'(dband_r))
                err = 0;
            sum = integ_acc + err;
            if (sum > longint'(ilim_r))
                sum = longint'(ilim_r);
            else if (sum < -longint'(ilim_r))
                sum = -longint'(ilim_r);
            integ_acc = sum;
            acc = longint'(gp_r) * err + longint'(gi_r) * sum
                + longint'(gd_r) * (err - prev_err);
            spd = clip16(acc / 256);
            if (side_sel == oapf_pkg::SIDE_LEFT)
                spd = clip16(-spd);
            r.spd_valid = 1'b1;
            r.speed     = spd[SPEED_W-1:0];
            prev_err    = err;
            // exact wheel difference, no wrap
            diff = longint'(t.lpos) - longint'(t.rpos);
            if (diff < 0)
                diff = -diff;
            if (diff < longint'(match_r))
            begin
                side_sel  = oapf_pkg::SIDE_NONE;
                fwd_flag  = 1'b1;
                integ_acc = 0;
                r.resume  = 1'b1;
            end
        end
        r.fwd = fwd_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Tick builders
    // ------------------------------------------------------------------------
    function automatic tick_t make_tick(
        input logic [SB-1:0] fr_near, fr_far, fl_far, fl_near, side_r, side_l,
        input logic rot_done, input logic signed [POS_W-1:0] lpos, rpos);
        tick_t t;
        t.fr_near     = fr_near;
        t.fr_far      = fr_far;
        t.fl_far      = fl_far;
        t.fl_near     = fl_near;
        t.side_r      = side_r;
        t.side_l      = side_l;
        t.rot_done    = rot_done;
        t.lpos        = lpos;
        t.rpos        = rpos;
        t.drain_first = 1'b0;
        return t;
    endfunction

    function automatic logic [SB-1:0] quiet_level();
        return SB'($urandom_range(0, int'(thr_r)));
    endfunction

    function automatic logic [SB-1:0] obstacle_level();
        if (thr_r == '1)
            return '1;
        return SB'($urandom_range(int'(thr_r) + 1, 4095));
    endfunction

    // side reading mostly around the target
    function automatic logic [SB-1:0] side_level();
        int v;
        if ($urandom_range(0, 4) == 0)
            return SB'($urandom);
        v = int'(tgt_r) + int'($urandom_range(0, 600)) - 300;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return SB'(v);
    endfunction

    function automatic tick_t noise_tick();
        return make_tick(SB'($urandom), SB'($urandom), SB'($urandom), SB'($urandom),
                         SB'($urandom), SB'($urandom), 1'($urandom), $urandom, $urandom);
    endfunction

    function automatic tick_t cruise_tick();
        return make_tick(quiet_level(), quiet_level(), quiet_level(), quiet_level(),
                         SB'($urandom), SB'($urandom), 1'($urandom), $urandom, $urandom);
    endfunction

    function automatic tick_t obstacle_tick();
        tick_t         t;
        logic [SB-1:0] lvl, other, right_v, left_v;
        t     = cruise_tick();
        lvl   = obstacle_level();
        other = SB'($urandom_range(0, int'(lvl)));
        case ($urandom_range(0, 2))
            0:
            begin
                right_v = lvl;
                left_v  = other;
            end
            1:
            begin
                right_v = other;
                left_v  = lvl;
            end
            default:
            begin
                // tie
                right_v = lvl;
                left_v  = lvl;
            end
        endcase
        if ($urandom_range(0, 1))
        begin
            t.fr_near = right_v;
            t.fl_near = left_v;
        end
        else
        begin
            t.fr_far = right_v;
            t.fl_far = left_v;
        end
        t.rot_done    = ($urandom_range(0, 2) == 0);
        t.drain_first = ($urandom_range(0, 11) == 0);
        return t;
    endfunction

    // closing: wheels close enough to end following, if the limit allows it
    function automatic tick_t follow_tick(input bit closing);
        tick_t  t;
        longint base, d;
        t = make_tick(SB'($urandom), SB'($urandom), SB'($urandom), SB'($urandom),
                      side_level(), side_level(), 1'b1, '0, '0);
        base = longint'($urandom_range(0, 2000000000)) - 1000000000;
        if (closing && match_r != 0)
            d = $urandom_range(0, int'(match_r) - 1);
        else
            d = longint'(match_r) + $urandom_range(0, 5000);
        if ($urandom_range(0, 1))
            d = -d;
        t.lpos = base[POS_W-1:0];
        t.rpos = POS_W'(base + d);
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int draw_wait();
        if (idle_mode == IDLE_NONE)
            return 0;
        if (idle_mode == IDLE_LIGHT)
            return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic queue_one(input tick_t t);
        sensor_ticks.push_back(t);
        ticks_queued++;
    endtask

    // Mostly full avoid/turn/follow/resume episodes, some pure noise
    task automatic queue_ticks(input int n);
        tick_t t;
        int    start;
        start = ticks_queued;
        while (ticks_queued - start < n)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                queue_one(noise_tick());
            end
            else
            begin
                repeat ($urandom_range(0, 3)) queue_one(cruise_tick());
                queue_one(obstacle_tick());
                repeat ($urandom_range(0, 2))
                begin
                    t          = follow_tick(1'b0);
                    t.rot_done = 1'b0;
                    queue_one(t);
                end
                repeat ($urandom_range(1, 10)) queue_one(follow_tick(1'b0));
                queue_one(follow_tick(1'b1));
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (ctl_checked != ticks_queued);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic apply_settings(
        input logic [TH_W-1:0] th, tg, db, input logic [LIMIT_W-1:0] il,
        input logic signed [GAIN_W-1:0] kp, ki, kd, input logic [MATCH_W-1:0] ml);
        thr_r   = th;
        tgt_r   = tg;
        dband_r = db;
        ilim_r  = il;
        gp_r    = kp;
        gi_r    = ki;
        gd_r    = kd;
        match_r = ml;
        write_reg(oapf_pkg::REG_FRONT_THRESHOLD,      CFG_DATA_W'(th));
        write_reg(oapf_pkg::REG_SIDE_TARGET,          CFG_DATA_W'(tg));
        write_reg(oapf_pkg::REG_ERROR_DEADBAND,       CFG_DATA_W'(db));
        write_reg(oapf_pkg::REG_INTEGRAL_LIMIT,       CFG_DATA_W'(il));
        write_reg(oapf_pkg::REG_GAIN_P,               CFG_DATA_W'($unsigned(kp)));
        write_reg(oapf_pkg::REG_GAIN_I,               CFG_DATA_W'($unsigned(ki)));
        write_reg(oapf_pkg::REG_GAIN_D,               CFG_DATA_W'($unsigned(kd)));
        write_reg(oapf_pkg::REG_POSITION_MATCH_LIMIT, CFG_DATA_W'(ml));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    function automatic logic [GAIN_W-1:0] random_gain();
        if ($urandom_range(0, 1))
            return GAIN_W'($urandom_range(0, 2048) - 1024);
        return GAIN_W'($urandom);
    endfunction

    task automatic random_settings();
        logic [TH_W-1:0]    th;
        logic [LIMIT_W-1:0] il;
        th = ($urandom_range(0, 7) == 0) ? TH_W'($urandom) : TH_W'($urandom_range(30, 2500));
        il = $urandom_range(0, 1) ? LIMIT_W'($urandom_range(0, 2000)) : LIMIT_W'($urandom);
        apply_settings(th, TH_W'($urandom), TH_W'($urandom_range(0, 150)), il,
                       random_gain(), random_gain(), random_gain(),
                       MATCH_W'($urandom_range(0, 3000)));
    endtask

    task automatic run_phase(input int n, input int mode);
        @(negedge clk);
        idle_mode = mode;
        queue_ticks(n);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued ticks, predicts each accepted beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                tx_want = control_step(tx_tick);
                expected_ctl.push_back(tx_want);
                ticks_sent++;
                if (tx_want.turn != oapf_pkg::NO_OBST)
                    turns_seen++;
                if (tx_want.spd_valid)
                    pid_runs++;
                if (tx_want.resume)
                    resumes_seen++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (sensor_ticks.size() != 0 &&
                         !(sensor_ticks[0].drain_first && ctl_checked != ticks_sent))
                begin
                    tx_tick = sensor_ticks.pop_front();
                    in_ch.front_right_near  <= tx_tick.fr_near;
                    in_ch.front_right_far   <= tx_tick.fr_far;
                    in_ch.front_left_far    <= tx_tick.fl_far;
                    in_ch.front_left_near   <= tx_tick.fl_near;
                    in_ch.side_right        <= tx_tick.side_r;
                    in_ch.side_left         <= tx_tick.side_l;
                    in_ch.rotation_finished <= tx_tick.rot_done;
                    in_ch.left_wheel_pos    <= tx_tick.lpos;
                    in_ch.right_wheel_pos   <= tx_tick.rpos;
                    in_ch.valid             <= 1'b1;
                    tx_gap = draw_wait();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: scores each result beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                rx_got.turn      = out_ch.turn_command;
                rx_got.spd_valid = out_ch.speed_valid;
                rx_got.speed     = out_ch.wheel_speed_adjust;
                rx_got.resume    = out_ch.resume_forward;
                rx_got.fwd       = out_ch.forward_mode;
                ctl_checked++;
                if (expected_ctl.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat %0d arrived with nothing expected", ctl_checked);
                end
                else
                begin
                    rx_want = expected_ctl.pop_front();
                    if (rx_got.turn !== rx_want.turn ||
                        rx_got.spd_valid !== rx_want.spd_valid ||
                        rx_got.speed !== rx_want.speed ||
                        rx_got.resume !== rx_want.resume ||
                        rx_got.fwd !== rx_want.fwd)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: expected turn=%0d sv=%0b speed=%0d res=%0b",
                                     ctl_checked, rx_want.turn, rx_want.spd_valid,
                                     rx_want.speed, rx_want.resume,
                                     " fwd=%0b / got turn=%0d sv=%0b speed=%0d res=%0b fwd=%0b",
                                     rx_want.fwd, rx_got.turn, rx_got.spd_valid,
                                     rx_got.speed, rx_got.resume, rx_got.fwd);
                    end
                end
                rx_wait = draw_wait();
            end
            if (hold_left != 0)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (rx_wait != 0)
            begin
                rx_wait--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off twice during the run, so the pipe fills and backs up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            beats_in  <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                beats_in <= beats_in + 1;
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (in_ch.valid && in_ch.ready && (beats_in == 300 || beats_in == 900))
                hold_left <= 250;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results checked",
                     cycles, ctl_checked, ticks_queued);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tick_t t;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        thr_r     = oapf_pkg::FRONT_THRESHOLD_RST;
        tgt_r     = oapf_pkg::SIDE_TARGET_RST;
        dband_r   = oapf_pkg::DEADBAND_RST;
        ilim_r    = oapf_pkg::INTEGRAL_LIMIT_RST;
        gp_r      = oapf_pkg::GAIN_P_RST;
        gi_r      = oapf_pkg::GAIN_I_RST;
        gd_r      = oapf_pkg::GAIN_D_RST;
        match_r   = oapf_pkg::MATCH_LIMIT_RST;
        fwd_flag  = 1'b1;
        side_sel  = oapf_pkg::SIDE_NONE;
        integ_acc = 0;
        prev_err  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks at reset settings
        @(negedge clk);
        idle_mode = IDLE_LIGHT;
        t = make_tick(0, 0, 0, 0, 0, 0, 0, oapf_pkg::WHEEL_POS_ZERO, oapf_pkg::WHEEL_POS_ZERO);
        t.drain_first = 1'b1;
        queue_one(t);                                                  // clear road
        queue_one(make_tick(4095, 0, 0, 0, 0, 0, 0, 0, 0));            // right near: turn left
        queue_one(make_tick(0, 0, 0, 0, 0, 0, 0, 100, 0));             // still turning
        queue_one(make_tick(0, 0, 0, 0, 0, 0, 1, 0, 1000));            // PID, max positive error
        queue_one(make_tick(0, 0, 0, 0, 4095, 0, 1, 0, 1000));         // large negative error
        queue_one(make_tick(0, 0, 0, 0, 95, 0, 1, 0, 1000));           // inside deadband
        queue_one(make_tick(0, 0, 0, 0, 50, 0, 1, 7, 7));              // wheels agree: resume
        queue_one(make_tick(500, 0, 0, 500, 0, 0, 1, 0, 1000));        // near tie, turn and PID
        queue_one(make_tick(0, 0, 0, 0, 0, 4095, 1, 0, 1000));         // left follow, negated
        queue_one(make_tick(0, 0, 0, 0, 0, 200, 1, 32'h7FFF_FFFF, 32'h8000_0000)); // no wrap
        queue_one(make_tick(0, 0, 0, 0, 0, 200, 1, 32'h8000_0000, 32'h8000_0005));
        queue_one(make_tick(0, 300, 200, 0, 0, 0, 0, 0, 0));           // far pair: turn left
        queue_one(make_tick(0, 0, 0, 0, 100, 0, 1, 3, 0));             // zero error, resume
        queue_one(make_tick(0, 4095, 4095, 0, 0, 0, 0, 0, 0));         // far tie: turn right
        queue_one(make_tick(0, 0, 0, 0, 0, 4095, 1, 32'hFFFF_FFFF, 8));
        queue_one(make_tick(100, 0, 101, 100, 0, 0, 0, 0, 0));         // near at threshold only
        queue_one(make_tick(4095, 4095, 4095, 4095, 0, 4095, 1, 0, 9999)); // fronts ignored
        queue_one(make_tick(0, 0, 0, 0, 0, 0, 1, 10, 0));              // diff equals limit
        queue_one(make_tick(0, 0, 0, 0, 0, 0, 1, 9, 0));               // just below limit
        queue_ticks(150);
        wait_drained();

        // Moderate settings
        apply_settings(12'd2000, 12'd1500, 12'd50, 20'd5000, 16'sd300, 16'sd20,
                       -16'sd100, 16'd1000);
        run_phase(200, IDLE_HEAVY);

        // Extremes: zero threshold, full target, most negative gains
        apply_settings(12'd0, 12'hFFF, 12'd0, 20'hFFFFF, 16'h8000, 16'h8000,
                       16'h8000, 16'hFFFF);
        @(negedge clk);
        t = make_tick(0, 0, 0, 0, 0, 0, 1, 0, 0);
        t.drain_first = 1'b1;
        queue_one(t);                                                  // nothing above zero
        queue_one(make_tick(0, 0, 1, 1, 0, 0, 1, 0, 100000));          // saturates, negated
        queue_one(make_tick(0, 0, 0, 0, 0, 4095, 1, 0, 100000));
        queue_one(make_tick(0, 0, 0, 0, 0, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF));
        queue_one(make_tick(0, 0, 0, 0, 0, 0, 1, 0, 65534));
        run_phase(150, IDLE_NONE);

        // Other extremes: wide deadband, zero integral limit, match never reached
        apply_settings(12'd1, 12'd0, 12'hFFF, 20'd0, 16'sd32767, 16'sd32767,
                       16'sd32767, 16'd0);
        run_phase(80, IDLE_LIGHT);

        // Threshold at full scale: no obstacle can be seen
        apply_settings(12'hFFF, 12'd2048, 12'd5, 20'd300, 16'sd512, 16'sd4,
                       16'sd64, 16'hFFFF);
        run_phase(40, IDLE_HEAVY);

        for (int i = 0; i < 5; i++)
        begin
            random_settings();
            run_phase(160, i % 3);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Covered %0d ticks over %0d register settings: %0d turns,",
                 ticks_sent, settings_cnt, turns_seen);
        $display("  %0d PID updates, %0d returns to forward driving", pid_runs, resumes_seen);
        if (mismatches == 0 && expected_ctl.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("%0d bad beats, %0d results missing", mismatches, expected_ctl.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
